FILE: sv/fhpa_pkg.sv
// Package for the fragment header parser and acker.
// Holds the field-position and result-kind codes, the result record and the
// decimal accumulate helper. No dependencies.
`default_nettype none

package fhpa_pkg;

    localparam int LEN_W    = 10;
    localparam int NUM_W    = 32;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [2:0] {
        FLD_TOTAL = 3'd0,
        FLD_FRAG  = 3'd1,
        FLD_SIZE  = 3'd2,
        FLD_NAME  = 3'd3,
        FLD_DATA  = 3'd4
    } t_field;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_NAME  = 2'd1,
        KIND_REPLY = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        out_byte;
        logic              is_ack;
        logic [NUM_W-1:0]  reply_number;
        logic              transfer_done;
        logic              header_error;
        logic              last_of_run;
    } t_result;

    // acc * 10 + digit, saturating at all ones.
    function automatic logic [NUM_W-1:0] acc_dec32(input logic [NUM_W-1:0] acc,
                                                   input logic [3:0] digit);
        logic [NUM_W+3:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NUM_W{1'b0}}, digit};
        if (v[NUM_W+3:NUM_W] != 4'd0) begin
            return '1;
        end
        return v[NUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/fhpa_if.sv
// Valid/ready channel interfaces for the datagram byte input and the result
// output. Depends on fhpa_pkg.
`default_nettype none

interface fhpa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_datagram;

    modport source (output valid, output byte_value, output end_of_datagram, input ready);
    modport sink   (input valid, input byte_value, input end_of_datagram, output ready);
endinterface

interface fhpa_out_if;
    import fhpa_pkg::*;
    logic             valid;
    logic             ready;
    t_kind            kind;
    logic [7:0]       out_byte;
    logic             is_ack;
    logic [NUM_W-1:0] reply_number;
    logic             transfer_done;
    logic             header_error;
    logic             last_of_run;

    modport source (output valid, output kind, output out_byte, output is_ack,
                    output reply_number, output transfer_done, output header_error,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input out_byte, input is_ack,
                    input reply_number, input transfer_done, input header_error,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: sv/fhpa_parser.sv
// Input register and per-byte parse step; produces up to two result words.
// Depends on fhpa_pkg.
`default_nettype none

module fhpa_parser #(
    parameter int MAX_PAYLOAD = 1000
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_eod,
    input  wire logic               i_room,
    output logic                    o_ready,
    output logic [1:0]              o_push,
    output fhpa_pkg::t_result       o_res_a,
    output fhpa_pkg::t_result       o_res_b
);
    import fhpa_pkg::*;

    localparam logic [LEN_W+3:0] CAP = (LEN_W+4)'(MAX_PAYLOAD);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_eod;

    t_field           r_pos, n_pos;
    logic             r_stopped, n_stopped;
    logic [NUM_W-1:0] r_total, n_total;
    logic [NUM_W-1:0] r_frag, n_frag;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_sent, n_sent;
    logic [NUM_W-1:0] r_exp, n_exp;
    logic             r_open, n_open;

    logic             step;
    logic             is_colon, is_digit;
    logic [3:0]       digit;
    logic [LEN_W+3:0] len_mul;
    logic             byte_out;
    t_result          byte_res, reply_res;
    logic [NUM_W-1:0] exp_eff;

    assign step    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready) begin
            r_in_byte <= i_byte;
            r_in_eod  <= i_eod;
        end
    end

    assign is_colon = (r_in_byte == CHAR_COLON);
    assign is_digit = (r_in_byte >= CHAR_ZERO) && (r_in_byte <= CHAR_NINE);
    assign digit    = 4'(r_in_byte - CHAR_ZERO);
    assign len_mul  = {1'b0, r_len, 3'b000} + {3'b000, r_len, 1'b0}
                    + {{LEN_W{1'b0}}, digit};
    assign exp_eff  = r_open ? r_exp : NUM_W'(1);

    always_comb begin
        n_pos     = r_pos;
        n_stopped = r_stopped;
        n_total   = r_total;
        n_frag    = r_frag;
        n_len     = r_len;
        n_sent    = r_sent;
        n_exp     = r_exp;
        n_open    = r_open;
        byte_out  = 1'b0;

        byte_res              = '0;
        byte_res.out_byte     = r_in_byte;
        byte_res.kind         = KIND_DATA;
        reply_res             = '0;
        reply_res.kind        = KIND_REPLY;
        reply_res.last_of_run = 1'b1;
        reply_res.reply_number = r_exp;

        if (r_pos != FLD_DATA) begin
            if (is_colon) begin
                n_stopped = 1'b0;
                case (r_pos)
                    FLD_TOTAL: n_pos = FLD_FRAG;
                    FLD_FRAG:  n_pos = FLD_SIZE;
                    FLD_SIZE:  n_pos = FLD_NAME;
                    default:   n_pos = FLD_DATA;
                endcase
            end else if (r_pos == FLD_NAME) begin
                if (!r_open) begin
                    byte_out      = 1'b1;
                    byte_res.kind = KIND_NAME;
                end
            end else if (!r_stopped && is_digit) begin
                case (r_pos)
                    FLD_TOTAL: n_total = acc_dec32(r_total, digit);
                    FLD_FRAG:  n_frag  = acc_dec32(r_frag, digit);
                    default:   n_len   = (len_mul > CAP) ? CAP[LEN_W-1:0]
                                                         : len_mul[LEN_W-1:0];
                endcase
            end else begin
                n_stopped = 1'b1;
            end
        end else if (r_sent < r_len) begin
            n_sent   = r_sent + LEN_W'(1);
            byte_out = 1'b1;
        end

        byte_res.last_of_run = !r_in_eod;

        if (r_in_eod) begin
            if (n_pos != FLD_DATA) begin
                reply_res.header_error = 1'b1;
            end else begin
                // The fragment number cannot change on the byte that completes the header.
                reply_res.reply_number  = exp_eff;
                reply_res.is_ack        = (r_frag == exp_eff);
                reply_res.transfer_done = (r_frag == r_total);
                n_exp  = exp_eff + NUM_W'(1);
                n_open = (r_frag != r_total);
            end
            n_pos     = FLD_TOTAL;
            n_stopped = 1'b0;
            n_total   = '0;
            n_frag    = '0;
            n_len     = '0;
            n_sent    = '0;
        end
    end

    always_comb begin
        o_push  = 2'd0;
        o_res_a = byte_out ? byte_res : reply_res;
        o_res_b = reply_res;
        if (step) begin
            o_push = 2'(byte_out) + 2'(r_in_eod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= FLD_TOTAL;
            r_stopped <= 1'b0;
            r_total   <= '0;
            r_frag    <= '0;
            r_len     <= '0;
            r_sent    <= '0;
            r_exp     <= NUM_W'(1);
            r_open    <= 1'b0;
        end else if (step) begin
            r_pos     <= n_pos;
            r_stopped <= n_stopped;
            r_total   <= n_total;
            r_frag    <= n_frag;
            r_len     <= n_len;
            r_sent    <= n_sent;
            r_exp     <= n_exp;
            r_open    <= n_open;
        end
    end

endmodule

`default_nettype wire

FILE: sv/fhpa_outq.sv
// Four-entry result queue that takes up to two words per cycle and gives one.
// Depends on fhpa_pkg.
`default_nettype none

module fhpa_outq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [1:0]         i_push,
    input  fhpa_pkg::t_result       i_res_a,
    input  fhpa_pkg::t_result       i_res_b,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output fhpa_pkg::t_result       o_res
);
    import fhpa_pkg::*;

    t_result            r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr, n_wr;
    logic [QPTR_W-1:0]  r_rd, n_rd;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic               pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    // Room for two words regardless of whether the head is taken this cycle.
    assign o_room  = (r_cnt <= QCNT_W'(QDEPTH - 2));

    always_comb begin
        n_wr  = r_wr + QPTR_W'(i_push);
        n_rd  = r_rd + QPTR_W'(pop);
        n_cnt = r_cnt + QCNT_W'(i_push) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_res_a;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wr + QPTR_W'(1)] <= i_res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: sv/fragment_header_parser_acker.sv
// A result word passes from the input register through the parse step into
// the result queue, which offers it. Throughput: one byte per cycle while the
// queue has room; the final byte of a datagram that also carries a data or
// name byte yields two words, drained one per cycle while the result side is ready.
// Reset: synchronous, active low; clears the parse state and the result
// queue, closes any transfer and sets the expected fragment number to one.
`default_nettype none

module fragment_header_parser_acker #(
    parameter int MAX_PAYLOAD = 1000
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fhpa_in_if.sink    i_data,
    fhpa_out_if.source o_result
);
    import fhpa_pkg::*;

    // Datagram bytes pass through a one-word input register into the parser.
    // The parser walks the total, fragment, size and name fields, one byte per
    // cycle while the queue has room, accumulating the decimal fields with
    // saturation, and then forwards at most size payload bytes. On the last byte
    // it builds the ack, nack or header-error reply. Each step writes up to two
    // words into a small queue that decouples it from result-side back-pressure.

    logic    room;
    logic [1:0] push;
    t_result res_a, res_b;
    t_result head;

    fhpa_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_data.valid),
        .i_byte  (i_data.byte_value),
        .i_eod   (i_data.end_of_datagram),
        .i_room  (room),
        .o_ready (i_data.ready),
        .o_push  (push),
        .o_res_a (res_a),
        .o_res_b (res_b)
    );

    // The queue keeps room for two words before the parser may take a step,
    // so a step never overflows it.
    fhpa_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res_a (res_a),
        .i_res_b (res_b),
        .o_room  (room),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_res   (head)
    );

    // Break the head word out onto the result channel fields.
    assign o_result.kind          = head.kind;
    assign o_result.out_byte      = head.out_byte;
    assign o_result.is_ack        = head.is_ack;
    assign o_result.reply_number  = head.reply_number;
    assign o_result.transfer_done = head.transfer_done;
    assign o_result.header_error  = head.header_error;
    assign o_result.last_of_run   = head.last_of_run;

endmodule

`default_nettype wire
